@@ rtl/core/byte_ring_fifo_with_packet_stage_unit_assert.svh @@
// ----------------------------------------------------------------------------
// byte ring fifo with packet stage: assertion macros
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_WITH_PACKET_STAGE_UNIT_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_PACKET_STAGE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define BRFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define BRFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BRFP_ASSERT_IMP(lbl, ante, cons, msg)
`define BRFP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/brfp_pkg.sv @@
// ----------------------------------------------------------------------------
// brfp_pkg
// types, sizes and helpers shared by the byte ring fifo with packet stage
// ----------------------------------------------------------------------------
package brfp_pkg;

  localparam int RING_DEPTH   = 1024;
  localparam int PACKET_BYTES = 64;

  localparam int RW   = $clog2(RING_DEPTH);
  localparam int RW1  = RW + 1;
  localparam int PKW  = $clog2(PACKET_BYTES);
  localparam int PSW  = $clog2(PACKET_BYTES + 1);
  localparam int AMW  = 10;
  localparam int CMPW = ((RW > AMW) ? RW : AMW) + 1;
  localparam int HDR_BYTES = 5;
  localparam int HDW  = $clog2(HDR_BYTES);
  localparam int CLR_LEN = (RING_DEPTH > PACKET_BYTES) ? RING_DEPTH : PACKET_BYTES;
  localparam int CLW  = $clog2(CLR_LEN);
  localparam int ADDR_BYTES = 4;

  typedef enum logic [2:0] {
    KIND_APPEND  = 3'd0,
    KIND_PEEK    = 3'd1,
    KIND_CONSUME = 3'd2,
    KIND_FLUSH   = 3'd3,
    KIND_MOVE    = 3'd4,
    KIND_PREAD   = 3'd5,
    KIND_RELEASE = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WAIT,
    ST_COPY,
    ST_RESP
  } state_t;

  typedef struct packed {
    kind_t          kind;
    logic [7:0]     data_byte;
    logic           burst_start;
    logic [AMW-1:0] amount;
    logic [AMW-1:0] offset;
  } in_item_t;

  typedef struct packed {
    logic [7:0]     read_byte;
    logic [AMW-1:0] done_count;
    logic [AMW-1:0] fifo_count;
    logic           fifo_full;
    logic [AMW-1:0] space_left;
    logic           overflow_seen;
    logic [6:0]     packet_count;
    logic           command_valid;
    logic [3:0]     command_code;
    logic [31:0]    target_address;
    logic [7:0]     payload_length;
  } out_item_t;

  typedef struct packed {
    logic          we;
    logic [RW-1:0] waddr;
    logic [7:0]    wdata;
    logic [RW-1:0] raddr;
  } ring_req_t;

  typedef struct packed {
    logic           we;
    logic [PKW-1:0] waddr;
    logic [7:0]     wdata;
    logic [PKW-1:0] raddr;
  } pkt_req_t;

  function automatic logic [RW-1:0] ring_wrap(input logic [RW:0] p);
    return (p >= RW1'(RING_DEPTH)) ? RW'(p - RW1'(RING_DEPTH)) : RW'(p);
  endfunction

endpackage

@@ rtl/core/brfp_ram.sv @@
// ----------------------------------------------------------------------------
// brfp_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module brfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/brfp_seq.sv @@
// ----------------------------------------------------------------------------
// brfp_seq
// request sequencer: pointers, burst tracking, packet copy loop and status
// ----------------------------------------------------------------------------
module brfp_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  brfp_pkg::in_item_t   in_data,
  output logic                 idle,
  output logic                 res_valid,
  output brfp_pkg::out_item_t  res_data,
  input  logic                 res_take,
  output brfp_pkg::ring_req_t  ring_req,
  input  logic [7:0]           ring_rdata,
  output brfp_pkg::pkt_req_t   pkt_req,
  input  logic [7:0]           pkt_rdata
);

  import brfp_pkg::*;

  state_t         state_r, state_nxt;
  in_item_t       cmd_r, cmd_nxt;
  logic [RW-1:0]  rp_r, rp_nxt;
  logic [RW-1:0]  wp_r, wp_nxt;
  logic           ovf_r, ovf_nxt;
  logic           bacc_r, bacc_nxt;
  logic [AMW-1:0] bleft_r, bleft_nxt;
  logic [PSW-1:0] psize_r, psize_nxt;
  logic [7:0]     hdr_r [HDR_BYTES];
  logic [7:0]     hdr_nxt [HDR_BYTES];
  logic [CLW-1:0] clr_r, clr_nxt;
  logic [7:0]     rd_r, rd_nxt;
  logic [AMW-1:0] done_r, done_nxt;
  logic           rok_r, rok_nxt;
  logic [RW-1:0]  src_r, src_nxt;
  logic [PSW-1:0] iss_r, iss_nxt;
  logic [PSW-1:0] len_r, len_nxt;
  logic           wv_r, wv_nxt;
  logic [PKW-1:0] wi_r, wi_nxt;

  logic [RW-1:0]  cnt;
  logic [RW-1:0]  space;
  logic           fits;
  logic           move_ok;

  // ring occupancy from the two pointers
  assign cnt = (wp_r >= rp_r) ? (wp_r - rp_r)
                              : RW'(RW1'(RING_DEPTH) - {1'b0, rp_r} + {1'b0, wp_r});
  assign space   = RW'(RING_DEPTH - 1) - cnt;
  assign fits    = CMPW'(cmd_r.amount) <= CMPW'(space);
  assign move_ok = (cmd_r.amount != '0) && (CMPW'(cmd_r.amount) <= CMPW'(cnt)) &&
                   (CMPW'(cmd_r.amount) <= CMPW'(PACKET_BYTES));

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RESP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      rp_r    <= '0;
      wp_r    <= '0;
      ovf_r   <= 1'b0;
      bacc_r  <= 1'b0;
      bleft_r <= '0;
      psize_r <= '0;
      clr_r   <= '0;
      iss_r   <= '0;
      wv_r    <= 1'b0;
      for (int i = 0; i < HDR_BYTES; i++) begin
        hdr_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      ovf_r   <= ovf_nxt;
      bacc_r  <= bacc_nxt;
      bleft_r <= bleft_nxt;
      psize_r <= psize_nxt;
      clr_r   <= clr_nxt;
      iss_r   <= iss_nxt;
      wv_r    <= wv_nxt;
      hdr_r   <= hdr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    rd_r   <= rd_nxt;
    done_r <= done_nxt;
    rok_r  <= rok_nxt;
    src_r  <= src_nxt;
    len_r  <= len_nxt;
    wi_r   <= wi_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    ovf_nxt   = ovf_r;
    bacc_nxt  = bacc_r;
    bleft_nxt = bleft_r;
    psize_nxt = psize_r;
    hdr_nxt   = hdr_r;
    clr_nxt   = clr_r;
    rd_nxt    = rd_r;
    done_nxt  = done_r;
    rok_nxt   = rok_r;
    src_nxt   = src_r;
    iss_nxt   = iss_r;
    len_nxt   = len_r;
    wv_nxt    = 1'b0;
    wi_nxt    = wi_r;

    ring_req.we    = 1'b0;
    ring_req.waddr = wp_r;
    ring_req.wdata = cmd_r.data_byte;
    ring_req.raddr = src_r;
    pkt_req.we     = 1'b0;
    pkt_req.waddr  = wi_r;
    pkt_req.wdata  = ring_rdata;
    pkt_req.raddr  = cmd_r.offset[PKW-1:0];

    case (state_r)
      ST_CLEAR: begin
        // zero both stores one entry per cycle
        ring_req.we    = (CLW + 1)'(clr_r) < (CLW + 1)'(RING_DEPTH);
        ring_req.waddr = RW'(clr_r);
        ring_req.wdata = '0;
        pkt_req.we     = (CLW + 1)'(clr_r) < (CLW + 1)'(PACKET_BYTES);
        pkt_req.waddr  = PKW'(clr_r);
        pkt_req.wdata  = '0;
        clr_nxt        = clr_r + 1'b1;
        if (clr_r == CLW'(CLR_LEN - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rd_nxt    = '0;
        done_nxt  = '0;
        state_nxt = ST_RESP;
        case (cmd_r.kind)
          KIND_APPEND: begin
            if (cmd_r.burst_start) begin
              if (fits) begin
                bacc_nxt  = 1'b1;
                bleft_nxt = cmd_r.amount;
                done_nxt  = cmd_r.amount;
              end else begin
                ovf_nxt   = 1'b1;
                bacc_nxt  = 1'b0;
                bleft_nxt = '0;
              end
            end
            if (bacc_nxt && (bleft_nxt != '0)) begin
              ring_req.we = 1'b1;
              wp_nxt      = ring_wrap({1'b0, wp_r} + RW1'(1));
              bleft_nxt   = bleft_nxt - 1'b1;
              if (!cmd_r.burst_start) begin
                done_nxt = AMW'(1);
              end
            end
            if (bleft_nxt == '0) begin
              bacc_nxt = 1'b0;
            end
          end
          KIND_PEEK: begin
            rok_nxt        = CMPW'(cmd_r.offset) < CMPW'(RING_DEPTH);
            ring_req.raddr = ring_wrap({1'b0, rp_r} + RW1'(cmd_r.offset));
            state_nxt      = ST_WAIT;
          end
          KIND_CONSUME: begin
            if (CMPW'(cmd_r.amount) <= CMPW'(cnt)) begin
              rp_nxt   = ring_wrap({1'b0, rp_r} + RW1'(cmd_r.amount));
              done_nxt = cmd_r.amount;
            end
          end
          KIND_FLUSH: begin
            rp_nxt = wp_r;
          end
          KIND_MOVE: begin
            if (move_ok) begin
              len_nxt   = PSW'(cmd_r.amount);
              src_nxt   = rp_r;
              iss_nxt   = '0;
              state_nxt = ST_COPY;
            end else begin
              psize_nxt = '0;
            end
          end
          KIND_PREAD: begin
            rok_nxt   = CMPW'(cmd_r.offset) < CMPW'(PACKET_BYTES);
            state_nxt = ST_WAIT;
          end
          KIND_RELEASE: begin
            psize_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      ST_WAIT: begin
        if (rok_r) begin
          rd_nxt = (cmd_r.kind == KIND_PEEK) ? ring_rdata : pkt_rdata;
        end
        state_nxt = ST_RESP;
      end
      ST_COPY: begin
        // read side runs one byte ahead of the write side
        if (iss_r != len_r) begin
          ring_req.raddr = src_r;
          src_nxt        = ring_wrap({1'b0, src_r} + RW1'(1));
          iss_nxt        = iss_r + 1'b1;
          wv_nxt         = 1'b1;
          wi_nxt         = iss_r[PKW-1:0];
        end
        if (wv_r) begin
          pkt_req.we = 1'b1;
          if ((PKW + 1)'(wi_r) < (PKW + 1)'(HDR_BYTES)) begin
            hdr_nxt[wi_r[HDW-1:0]] = ring_rdata;
          end
          if (PSW'(wi_r) + PSW'(1) == len_r) begin
            rp_nxt    = src_r;
            psize_nxt = len_r;
            done_nxt  = AMW'(len_r);
            state_nxt = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // status as seen after the request
  always_comb begin
    res_data.read_byte      = rd_r;
    res_data.done_count     = done_r;
    res_data.fifo_count     = AMW'(cnt);
    res_data.fifo_full      = (cnt == RW'(RING_DEPTH - 1));
    res_data.space_left     = AMW'(space);
    res_data.overflow_seen  = ovf_r;
    res_data.packet_count   = 7'(psize_r);
    res_data.command_valid  = (psize_r != '0);
    res_data.command_code   = (psize_r != '0) ? hdr_r[0][7:4] : 4'h0;
    res_data.target_address = (psize_r >= PSW'(ADDR_BYTES))
                              ? {4'h0, hdr_r[0][3:0], hdr_r[1], hdr_r[2], hdr_r[3]}
                              : '1;
    res_data.payload_length = (psize_r >= PSW'(HDR_BYTES)) ? hdr_r[4] : 8'h00;
  end

endmodule

@@ rtl/core/byte_ring_fifo_with_packet_stage_unit.sv @@
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_packet_stage_unit
// byte ring fifo with burst admission and a linear packet stage
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_stall/in_data carry one request (append byte, peek, consume,
//   flush, move to packet, packet read, packet release). out_valid/out_stall/
//   out_data return exactly one status result per request.
//   a request is taken only while the sequencer is idle; in_stall is high
//   from the cycle after acceptance until its result enters the output reg.
//   a request passes the exec state and then the result state for append,
//   consume, flush, release and a refused move; peek and packet read add a
//   wait state for the registered ram read, and a good move adds a copy state
//   that copies one byte per cycle through the ring ram read port into the
//   packet ram. the output register lets the next request be accepted
//   while a result waits.
//   after reset a clearing pass zeroes both memories, one entry per cycle,
//   over max(RING_DEPTH, PACKET_BYTES) = 1024 addresses; in_stall is high then.
//   when the receiver stalls, out_data holds and the sequencer waits with the
//   next result until the output register frees.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_packet_stage_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  brfp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output brfp_pkg::out_item_t out_data
);

  import brfp_pkg::*;

  `include "byte_ring_fifo_with_packet_stage_unit_assert.svh"

  logic       seq_idle;
  logic       res_valid;
  out_item_t  res_data;
  logic       res_take;
  ring_req_t  ring_req;
  pkt_req_t   pkt_req;
  logic [7:0] ring_rdata;
  logic [7:0] pkt_rdata;
  logic       out_valid_r;
  out_item_t  out_data_r;

  assign res_take = !out_valid_r || !out_stall;
  assign in_stall = !seq_idle;

  brfp_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .idle       (seq_idle),
    .res_valid  (res_valid),
    .res_data   (res_data),
    .res_take   (res_take),
    .ring_req   (ring_req),
    .ring_rdata (ring_rdata),
    .pkt_req    (pkt_req),
    .pkt_rdata  (pkt_rdata)
  );

  brfp_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring_ram (
    .clk   (clk),
    .we    (ring_req.we),
    .waddr (ring_req.waddr),
    .wdata (ring_req.wdata),
    .raddr (ring_req.raddr),
    .rdata (ring_rdata)
  );

  brfp_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_pkt_ram (
    .clk   (clk),
    .we    (pkt_req.we),
    .waddr (pkt_req.waddr),
    .wdata (pkt_req.wdata),
    .raddr (pkt_req.raddr),
    .rdata (pkt_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BRFP_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted request did not stall input")
  `BRFP_ASSERT_IMP(a_count_plus_space, out_valid, AMW'(out_data.fifo_count + out_data.space_left) == AMW'(RING_DEPTH - 1), "fifo count and space disagree")
  `BRFP_ASSERT_IMP(a_cmd_valid, out_valid, out_data.command_valid == (out_data.packet_count != 7'd0), "command valid disagrees with packet count")
  `BRFP_ASSERT_IMP(a_addr_sentinel, out_valid && (out_data.packet_count < 7'd4), out_data.target_address == 32'hFFFF_FFFF, "short packet without address sentinel")

endmodule

@@ sim/tb_byte_ring_fifo_with_packet_stage_unit.sv @@
// ----------------------------------------------------------------------------
// tb_byte_ring_fifo_with_packet_stage_unit
// drives append bursts, peeks, consumes, flushes, packet moves, packet reads
// and releases with random sender gaps and receiver stalls, and compares
// every status result with a cycle-free model of the ring and packet store
// ----------------------------------------------------------------------------
module tb_byte_ring_fifo_with_packet_stage_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import brfp_pkg::*;

  localparam kind_t KIND_SPARE   = kind_t'(3'd7);
  localparam int    RANDOM_ITEMS = 1470;
  localparam int    FILL_END     = 1100;
  localparam int    MIXED_END    = 1300;
  localparam int    TAIL_CYCLES  = 80;
  localparam int    DRAIN_LIMIT  = 5000;

  class ring_status_book;
    bit [7:0]    ring_mem [RING_DEPTH];
    bit [7:0]    pkt_mem [PACKET_BYTES];
    int unsigned rd_ptr, wr_ptr, burst_rem, pkt_len;
    bit          ovf_flag, taking;
    out_item_t   pending_status [$];
    int          mismatches;

    function new();
      foreach (ring_mem[i]) ring_mem[i] = '0;
      foreach (pkt_mem[i]) pkt_mem[i] = '0;
      rd_ptr = 0;
      wr_ptr = 0;
      burst_rem = 0;
      pkt_len = 0;
      ovf_flag = 0;
      taking = 0;
      mismatches = 0;
    endfunction

    function int unsigned fill_level();
      return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : RING_DEPTH - rd_ptr + wr_ptr;
    endfunction

    function int unsigned advance(int unsigned p);
      return (p >= RING_DEPTH) ? p - RING_DEPTH : p;
    endfunction

    // apply one accepted request and queue the status it should produce
    function void note_request(in_item_t req);
      out_item_t   want;
      int unsigned cnt, space, rd, done, i;
      cnt = fill_level();
      space = RING_DEPTH - 1 - cnt;
      rd = 0;
      done = 0;
      case (req.kind)
        KIND_APPEND: begin
          if (req.burst_start) begin
            if (req.amount <= space) begin
              taking = 1;
              burst_rem = req.amount;
              done = req.amount;
            end else begin
              ovf_flag = 1;
              taking = 0;
              burst_rem = 0;
            end
          end
          if (taking && burst_rem > 0) begin
            ring_mem[wr_ptr] = req.data_byte;
            wr_ptr = advance(wr_ptr + 1);
            burst_rem--;
            if (!req.burst_start) done = 1;
          end
          if (burst_rem == 0) taking = 0;
        end
        KIND_PEEK: begin
          if (req.offset < RING_DEPTH) rd = ring_mem[advance(rd_ptr + req.offset)];
        end
        KIND_CONSUME: begin
          if (req.amount <= cnt) begin
            rd_ptr = advance(rd_ptr + req.amount);
            done = req.amount;
          end
        end
        KIND_FLUSH: begin
          rd_ptr = wr_ptr;
        end
        KIND_MOVE: begin
          if (cnt != 0 && req.amount != 0 && req.amount <= cnt &&
              req.amount <= PACKET_BYTES) begin
            for (i = 0; i < req.amount; i++)
              pkt_mem[i] = ring_mem[advance(rd_ptr + i)];
            rd_ptr = advance(rd_ptr + req.amount);
            pkt_len = req.amount;
          end else begin
            pkt_len = 0;
          end
          done = pkt_len;
        end
        KIND_PREAD: begin
          if (req.offset < PACKET_BYTES) rd = pkt_mem[req.offset];
        end
        KIND_RELEASE: begin
          pkt_len = 0;
        end
        default: ;
      endcase
      cnt = fill_level();
      space = RING_DEPTH - 1 - cnt;
      want = '0;
      want.read_byte = rd[7:0];
      want.done_count = done[AMW-1:0];
      want.fifo_count = cnt[AMW-1:0];
      want.fifo_full = (cnt == RING_DEPTH - 1);
      want.space_left = space[AMW-1:0];
      want.overflow_seen = ovf_flag;
      want.packet_count = pkt_len[6:0];
      want.command_valid = (pkt_len != 0);
      want.command_code = (pkt_len != 0) ? pkt_mem[0][7:4] : 4'h0;
      want.target_address = (pkt_len >= 4) ?
          {4'h0, pkt_mem[0][3:0], pkt_mem[1], pkt_mem[2], pkt_mem[3]} : 32'hFFFF_FFFF;
      want.payload_length = (pkt_len >= 5) ? pkt_mem[4] : 8'h00;
      pending_status.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      if (pending_status.size() == 0) begin
        $error("status result with no request outstanding");
        mismatches++;
        return;
      end
      want = pending_status.pop_front();
      compare_field("read_byte", want.read_byte, got.read_byte);
      compare_field("done_count", want.done_count, got.done_count);
      compare_field("fifo_count", want.fifo_count, got.fifo_count);
      compare_field("fifo_full", want.fifo_full, got.fifo_full);
      compare_field("space_left", want.space_left, got.space_left);
      compare_field("overflow_seen", want.overflow_seen, got.overflow_seen);
      compare_field("packet_count", want.packet_count, got.packet_count);
      compare_field("command_valid", want.command_valid, got.command_valid);
      compare_field("command_code", want.command_code, got.command_code);
      compare_field("target_address", want.target_address, got.target_address);
      compare_field("payload_length", want.payload_length, got.payload_length);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  ring_status_book book = new();

  int unsigned burst_budget = 0;
  int unsigned sent = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  byte_ring_fifo_with_packet_stage_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // receiver: takes results and switches between calm, light and heavy stalling
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      book.check_status(out_data);
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(32, 256);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic in_item_t op(kind_t k, int unsigned data, bit start,
                                  int unsigned amt, int unsigned ofs);
    in_item_t r;
    r.kind = k;
    r.data_byte = data[7:0];
    r.burst_start = start;
    r.amount = amt[AMW-1:0];
    r.offset = ofs[AMW-1:0];
    return r;
  endfunction

  function automatic in_item_t noise_item(kind_t k);
    return op(k, $urandom_range(0, 255), 1'($urandom_range(0, 1)),
              $urandom_range(0, 1023), $urandom_range(0, 1023));
  endfunction

  // sender: bursts of requests separated by idle gaps
  task automatic issue(input in_item_t req);
    int unsigned gap;
    if (burst_budget == 0) begin
      burst_budget = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 300)
                                                 : $urandom_range(1, 16);
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_budget--;
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    book.note_request(req);
    sent++;
  endtask

  task automatic run_directed();
    issue(op(KIND_PEEK, 0, 0, 0, 0));
    issue(op(KIND_PEEK, 0, 0, 0, 1023));
    issue(op(KIND_CONSUME, 0, 0, 1, 0));
    issue(op(KIND_MOVE, 0, 0, 0, 0));
    issue(op(KIND_PREAD, 0, 0, 0, 63));
    issue(op(KIND_PREAD, 0, 0, 0, 1023));
    // zero-length burst, then a stray byte with no burst open
    issue(op(KIND_APPEND, 8'hFF, 1, 0, 0));
    issue(op(KIND_APPEND, 8'h77, 0, 0, 0));
    issue(op(KIND_APPEND, 8'hA5, 1, 6, 0));
    issue(op(KIND_APPEND, 8'h12, 0, 0, 0));
    issue(op(KIND_APPEND, 8'h34, 0, 0, 0));
    issue(op(KIND_APPEND, 8'h56, 0, 0, 0));
    issue(op(KIND_APPEND, 8'h78, 0, 0, 0));
    issue(op(KIND_APPEND, 8'h09, 0, 0, 0));
    // byte past the declared length
    issue(op(KIND_APPEND, 8'hEE, 0, 0, 0));
    // refused burst, its following byte is dropped too
    issue(op(KIND_APPEND, 8'h00, 1, 1023, 0));
    issue(op(KIND_APPEND, 8'h55, 0, 0, 0));
    issue(op(KIND_PEEK, 0, 0, 0, 5));
    issue(op(KIND_MOVE, 0, 0, 7, 0));
    issue(op(KIND_MOVE, 0, 0, 6, 0));
    issue(op(KIND_PREAD, 0, 0, 0, 4));
    issue(op(KIND_MOVE, 0, 0, 65, 0));
    issue(op(KIND_CONSUME, 0, 0, 0, 0));
    issue(op(KIND_RELEASE, 0, 0, 0, 0));
    issue(op(KIND_FLUSH, 0, 0, 0, 0));
    issue(op(KIND_SPARE, 0, 0, 0, 0));
  endtask

  task automatic send_burst();
    int unsigned room, amt, body, extra, pick, i;
    in_item_t    r;
    room = RING_DEPTH - 1 - book.fill_level();
    pick = $urandom_range(0, 99);
    if (pick < 70) amt = $urandom_range(1, 24);
    else if (pick < 78) amt = room;
    else if (pick < 86) amt = (room < 1023) ? room + 1 : 1023;
    else if (pick < 90) amt = 0;
    else amt = $urandom_range(25, 1023);
    r = noise_item(KIND_APPEND);
    r.burst_start = 1'b1;
    r.amount = amt[AMW-1:0];
    issue(r);
    body = (amt > 0) ? amt - 1 : 0;
    if (body > 40) body = $urandom_range(0, 40);
    else if ($urandom_range(0, 19) == 0) body = $urandom_range(0, body);
    extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
    for (i = 0; i < body + extra; i++) begin
      r = noise_item(KIND_APPEND);
      r.burst_start = 1'b0;
      issue(r);
    end
  endtask

  task automatic run_random();
    int unsigned base, done_items, pick, cnt, lim [7];
    in_item_t    r;
    base = sent;
    while (sent - base < RANDOM_ITEMS) begin
      done_items = sent - base;
      // long fill phase first so the ring reaches full, then mixed, then drain
      if (done_items < FILL_END) lim = '{88, 93, 95, 97, 99, 100, 100};
      else if (done_items < MIXED_END) lim = '{45, 55, 67, 82, 90, 95, 97};
      else lim = '{22, 32, 52, 82, 92, 96, 98};
      cnt = book.fill_level();
      pick = $urandom_range(0, 99);
      if (pick < lim[0]) begin
        send_burst();
      end else if (pick < lim[1]) begin
        r = noise_item(KIND_PEEK);
        if ($urandom_range(0, 9) < 7)
          r.offset = AMW'($urandom_range(0, (cnt == 0) ? 0 : cnt - 1));
        issue(r);
      end else if (pick < lim[2]) begin
        r = noise_item(KIND_CONSUME);
        pick = $urandom_range(0, 99);
        if (pick < 60) r.amount = AMW'($urandom_range(0, (cnt < 16) ? cnt : 16));
        else if (pick < 70) r.amount = cnt[AMW-1:0];
        else if (pick < 80) r.amount = AMW'((cnt < 1023) ? cnt + 1 : 1023);
        issue(r);
      end else if (pick < lim[3]) begin
        r = noise_item(KIND_MOVE);
        pick = $urandom_range(0, 99);
        if (pick < 60)
          r.amount = AMW'($urandom_range(1, (cnt == 0) ? 1 : ((cnt < 64) ? cnt : 64)));
        else if (pick < 68) r.amount = AMW'(PACKET_BYTES);
        else if (pick < 74) r.amount = AMW'(PACKET_BYTES + 1);
        else if (pick < 80) r.amount = '0;
        else if (pick < 86) r.amount = AMW'((cnt < 1023) ? cnt + 1 : 1023);
        issue(r);
      end else if (pick < lim[4]) begin
        r = noise_item(KIND_PREAD);
        if ($urandom_range(0, 9) < 8) r.offset = AMW'($urandom_range(0, PACKET_BYTES - 1));
        issue(r);
      end else if (pick < lim[5]) begin
        issue(noise_item(KIND_RELEASE));
      end else if (pick < lim[6]) begin
        issue(noise_item(KIND_FLUSH));
      end else begin
        issue(noise_item(KIND_SPARE));
      end
    end
  endtask

  initial begin
    int guard;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    in_valid <= 1'b0;
    guard = 0;
    while (book.pending_status.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.pending_status.size() != 0) begin
      $error("%0d status results never arrived", book.pending_status.size());
      book.mismatches++;
    end
    if (book.mismatches == 0) begin
      $display("byte_ring_fifo_with_packet_stage_unit test passed");
    end else begin
      $display("byte_ring_fifo_with_packet_stage_unit test failed");
    end
    $finish;
  end

  // covers the clearing pass, long moves and heavy stalling several times over
  initial begin
    #15_000_000;
    $display("byte_ring_fifo_with_packet_stage_unit test failed");
    $finish;
  end

endmodule
